@@ sv/twv_pkg.sv @@
// Package for the time-window VWAP block: widths, payload structs, controller states
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package twv_pkg;
    localparam int WINDOW_DEPTH = 4096;
    localparam int TIME_BITS    = 48;
    localparam int PRICE_BITS   = 24;
    localparam int VOLUME_BITS  = 24;
    localparam int IDX_BITS     = $clog2(WINDOW_DEPTH);
    localparam int CNT_BITS     = $clog2(WINDOW_DEPTH + 1);
    localparam int PV_BITS      = 60;
    localparam int VS_BITS      = 36;
    localparam int CFG_BITS     = 32;
    localparam int VWAP_BITS    = 24;
    localparam int DIV_CNT_BITS = $clog2(PV_BITS + 1);
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(60000);

    typedef struct packed {
        logic [TIME_BITS-1:0]   trade_time;
        logic [PRICE_BITS-1:0]  trade_price;
        logic [VOLUME_BITS-1:0] trade_size;
    } trade_t;

    typedef struct packed {
        logic [VWAP_BITS-1:0] vwap;
        logic                 vwap_valid;
        logic [12:0]          window_count;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_WAIT, ST_CHECK, ST_DROP, ST_APPEND, ST_DIV_START,
        ST_DIV, ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;    // capture the input word
        logic read_oldest;  // issue memory read at the oldest index
        logic drop;         // subtract the read entry and advance oldest
        logic append;       // write new trade and add it to the sums
        logic div_start;
        logic div_step;
        logic out_load;     // capture the result word
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic expired;
        logic div_done;
    } dp_status_t;
endpackage
`default_nettype wire

@@ sv/time_window_vwap.sv @@
// Volume-weighted average price over a sliding time window of trades held in a
// 4096-entry ring memory. One trade in, one result out. The result comes from a
// 60-step bit-serial divide, and eviction reads the memory one entry at a time.
// The result sits in an output register, loaded once the previous result is
// taken, and the next trade is taken as soon as it is loaded.
// window_length_ms is written through the cfg port; the user must write it only
// while the block is idle, as the block itself does not enforce it.
`default_nettype none
module time_window_vwap import twv_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire trade_t              s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output result_t                  m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_BITS-1:0] cfg_data
);
    logic [CFG_BITS-1:0] window_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       out_busy;

    assign cfg_ready = 1'b1;
    assign out_busy  = m_valid && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn)       window_reg <= WINDOW_RESET;
        else if (cfg_valid) window_reg <= cfg_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)          m_valid <= 1'b0;
        else if (cmd.out_load) m_valid <= 1'b1;
        else if (m_ready)      m_valid <= 1'b0;
    end

    twv_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .out_busy(out_busy), .status(status), .cmd(cmd)
    );

    twv_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_data(s_data), .window_length(window_reg),
        .cmd(cmd), .status(status), .result(m_data)
    );
endmodule
`default_nettype wire

@@ sv/twv_ctrl.sv @@
// Controller state machine for the time-window VWAP block.
// Depends on twv_pkg; drives commands into twv_datapath.
`default_nettype none
module twv_ctrl import twv_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       out_busy,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);
    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (status.empty) begin
                    state_next = ST_APPEND;
                end else begin
                    cmd.read_oldest = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: state_next = ST_CHECK;
            ST_CHECK: begin
                // Expired entries go one a pass; a full store loses its oldest once.
                if (status.expired || status.full) begin
                    cmd.drop = 1'b1;
                    state_next = status.expired ? ST_READ : ST_APPEND;
                end else begin
                    state_next = ST_APPEND;
                end
            end
            ST_DROP: state_next = ST_APPEND;
            ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (!out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ sv/twv_datapath.sv @@
// Datapath for the time-window VWAP block: ring store, running sums, serial divider.
// Depends on twv_pkg; commanded by twv_ctrl.
`default_nettype none
module twv_datapath import twv_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire trade_t              s_data,
    input  wire logic [CFG_BITS-1:0] window_length,
    input  wire dp_cmd_t             cmd,
    output dp_status_t               status,
    output result_t                  result
);
    localparam int ENTRY_BITS = TIME_BITS + PRICE_BITS + VOLUME_BITS;
    localparam int PROD_BITS  = PRICE_BITS + VOLUME_BITS;

    logic [ENTRY_BITS-1:0] mem [WINDOW_DEPTH];
    logic [ENTRY_BITS-1:0] rd_reg;
    trade_t                item_reg;
    logic [IDX_BITS-1:0]   oldest_reg, next_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [PV_BITS-1:0]    pv_sum_reg;
    logic [VS_BITS-1:0]    vol_sum_reg;
    logic [PV_BITS-1:0]    rem_reg;
    logic [VWAP_BITS-1:0]  quo_reg;
    logic [VS_BITS-1:0]    part_reg;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg;

    logic [TIME_BITS-1:0]   rd_time;
    logic [PRICE_BITS-1:0]  rd_price;
    logic [VOLUME_BITS-1:0] rd_vol;
    logic [TIME_BITS-1:0]   age;
    logic [PROD_BITS-1:0]   rd_prod, new_prod;
    logic [PV_BITS-1:0]     rd_pv, new_pv;
    logic [VS_BITS:0]       part_shift;
    logic [VS_BITS:0]       part_diff;

    assign {rd_time, rd_price, rd_vol} = rd_reg;
    assign age      = item_reg.trade_time - rd_time;
    assign rd_prod  = rd_price * rd_vol;
    assign new_prod = item_reg.trade_price * item_reg.trade_size;
    assign rd_pv    = PV_BITS'(rd_prod);
    assign new_pv   = PV_BITS'(new_prod);

    assign status.empty    = (count_reg == '0);
    assign status.full     = (count_reg == CNT_BITS'(WINDOW_DEPTH));
    assign status.expired  = (item_reg.trade_time > rd_time)
                             && (age > TIME_BITS'(window_length));
    assign status.div_done = (div_cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.read_oldest) rd_reg <= mem[oldest_reg];
        if (cmd.append) begin
            mem[next_reg] <= {item_reg.trade_time, item_reg.trade_price,
                              item_reg.trade_size};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) item_reg <= s_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg  <= '0;
            next_reg    <= '0;
            count_reg   <= '0;
            pv_sum_reg  <= '0;
            vol_sum_reg <= '0;
        end else if (cmd.drop) begin
            pv_sum_reg  <= pv_sum_reg - rd_pv;
            vol_sum_reg <= vol_sum_reg - VS_BITS'(rd_vol);
            oldest_reg  <= oldest_reg + 1'b1;
            count_reg   <= count_reg - 1'b1;
        end else if (cmd.append) begin
            pv_sum_reg  <= pv_sum_reg + new_pv;
            vol_sum_reg <= vol_sum_reg + VS_BITS'(item_reg.trade_size);
            next_reg    <= next_reg + 1'b1;
            count_reg   <= count_reg + 1'b1;
        end
    end

    // Restoring division, one quotient bit per cycle. The partial remainder
    // stays below the divisor, and the quotient never exceeds the largest
    // price, so only its low bits are kept.
    assign part_shift = {part_reg, rem_reg[PV_BITS-1]};
    assign part_diff  = part_shift - {1'b0, vol_sum_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_start) begin
            div_cnt_reg <= DIV_CNT_BITS'(PV_BITS);
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg  <= pv_sum_reg;
            quo_reg  <= '0;
            part_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= {rem_reg[PV_BITS-2:0], 1'b0};
            if (part_shift >= {1'b0, vol_sum_reg}) begin
                part_reg <= part_diff[VS_BITS-1:0];
                quo_reg  <= {quo_reg[VWAP_BITS-2:0], 1'b1};
            end else begin
                part_reg <= part_shift[VS_BITS-1:0];
                quo_reg  <= {quo_reg[VWAP_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            result.vwap_valid   <= (vol_sum_reg != '0);
            result.vwap         <= (vol_sum_reg != '0) ? quo_reg : '0;
            result.window_count <= 13'(count_reg);
        end
    end
endmodule
`default_nettype wire
